### rtl/cttt_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the task timer table.
package cttt_pkg;

    localparam int SLOTS       = 16;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int MAX_RESULTS = 16;
    localparam int FOUND_W     = $clog2(MAX_RESULTS + 1);

    localparam int REQ_W      = 2;
    localparam int TAG_W      = 8;
    localparam int TICKS_W    = 16;
    localparam int IDX_W      = 4;
    localparam int STATUS_W   = 3;
    localparam int OUT_SLOT_W = 4;
    localparam int PEND_W     = 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK = 2'd0,
        REQ_ADD  = 2'd1,
        REQ_DEL  = 2'd2,
        REQ_DISP = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_RUN     = 3'd0,
        ST_ADDED   = 3'd1,
        ST_FULL    = 3'd2,
        ST_DELETED = 3'd3,
        ST_EMPTY   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        OSEL_RUN,
        OSEL_RUN_LAST,
        OSEL_ADDED,
        OSEL_FULL,
        OSEL_DEL
    } t_out_sel;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [TICKS_W-1:0] delay;
        logic [TICKS_W-1:0] period;
        logic [PEND_W-1:0]  pending;
    } t_slot_rec;

    localparam int REC_W = $bits(t_slot_rec);

    typedef struct packed {
        logic     ld_req;
        logic     cnt_clr;
        logic     cnt_inc;
        logic     tick_wr;
        logic     disp_take;
        logic     add_wr;
        logic     del_do;
        logic     out_ld;
        t_out_sel out_sel;
        logic     hold_clr;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic slot_free;
        logic run;
        logic cnt_last;
        logic found_last;
        logic hold_valid;
    } t_dp_sts;

    function automatic logic [OUT_SLOT_W-1:0] to_out_slot(input logic [SLOT_W-1:0] s);
        return OUT_SLOT_W'(s);
    endfunction

endpackage

### rtl/cttt_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
module cttt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/cttt_dp.sv
`timescale 1ns / 1ps
// Datapath: slot store, valid bits, scan counter, held run word and output register.
module cttt_dp
    import cttt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic [TAG_W-1:0]      i_task_tag,
    input  logic [TICKS_W-1:0]    i_delay_ticks,
    input  logic [TICKS_W-1:0]    i_period_ticks,
    input  logic [IDX_W-1:0]      i_slot_index,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [STATUS_W-1:0]   o_status,
    output logic [TAG_W-1:0]      o_out_tag,
    output logic [OUT_SLOT_W-1:0] o_out_slot,
    output logic                  o_last
);

    logic [SLOTS-1:0]      r_valid;
    logic [SLOT_W-1:0]     r_cnt;
    logic [SLOT_W-1:0]     n_cnt;
    logic [FOUND_W-1:0]    r_found;
    logic                  r_hold_valid;
    logic [TAG_W-1:0]      r_hold_tag;
    logic [SLOT_W-1:0]     r_hold_slot;
    logic [TAG_W-1:0]      r_tag;
    logic [TICKS_W-1:0]    r_delay;
    logic [TICKS_W-1:0]    r_period;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_out_valid;
    t_status               r_status;
    logic [TAG_W-1:0]      r_out_tag;
    logic [OUT_SLOT_W-1:0] r_out_slot;
    logic                  r_last;

    t_slot_rec             rd_rec;
    t_slot_rec             wr_rec;
    logic [REC_W-1:0]      rd_data;
    logic                  we;
    logic                  cnt_last;
    logic                  out_free;
    logic [SLOT_W-1:0]     del_sel;
    logic                  del_hit;

    assign rd_rec   = t_slot_rec'(rd_data);
    assign cnt_last = (r_cnt == SLOT_W'(SLOTS - 1));
    assign out_free = !r_out_valid || i_out_ready;
    assign del_sel  = SLOT_W'(r_idx);
    assign del_hit  = (32'(r_idx) < 32'(SLOTS)) && r_valid[del_sel];

    // wrap at the last slot so a write never meets the read of the same slot
    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.cnt_clr) begin
            n_cnt = '0;
        end else if (i_cmd.cnt_inc) begin
            n_cnt = cnt_last ? '0 : r_cnt + SLOT_W'(1);
        end
    end

    always_comb begin
        we     = 1'b0;
        wr_rec = rd_rec;
        if (i_cmd.tick_wr && r_valid[r_cnt]) begin
            we = 1'b1;
            if (rd_rec.delay == '0) begin
                if (rd_rec.pending != '1) begin
                    wr_rec.pending = rd_rec.pending + PEND_W'(1);
                end
                if (rd_rec.period != '0) begin
                    wr_rec.delay = rd_rec.period;
                end
            end else begin
                wr_rec.delay = rd_rec.delay - TICKS_W'(1);
            end
        end
        if (i_cmd.disp_take) begin
            we             = 1'b1;
            wr_rec.pending = rd_rec.pending - PEND_W'(1);
        end
        if (i_cmd.add_wr) begin
            we             = 1'b1;
            wr_rec.tag     = r_tag;
            wr_rec.delay   = r_delay;
            wr_rec.period  = r_period;
            wr_rec.pending = '0;
        end
    end

    cttt_ram #(
        .WIDTH(REC_W),
        .DEPTH(SLOTS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_cnt),
        .i_wdata(wr_rec),
        .i_raddr(n_cnt),
        .o_rdata(rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_cnt        <= '0;
            r_found      <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (i_cmd.ld_req) begin
                r_found <= '0;
            end else if (i_cmd.disp_take) begin
                r_found <= r_found + FOUND_W'(1);
            end
            if (i_cmd.disp_take) begin
                r_hold_valid <= 1'b1;
                if (rd_rec.period == '0) begin
                    r_valid[r_cnt] <= 1'b0;
                end
            end else if (i_cmd.hold_clr) begin
                r_hold_valid <= 1'b0;
            end
            if (i_cmd.add_wr) begin
                r_valid[r_cnt] <= 1'b1;
            end
            if (i_cmd.del_do && del_hit) begin
                r_valid[del_sel] <= 1'b0;
            end
            if (i_cmd.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_req) begin
            r_tag    <= i_task_tag;
            r_delay  <= i_delay_ticks;
            r_period <= i_period_ticks;
            r_idx    <= i_slot_index;
        end
        if (i_cmd.disp_take) begin
            r_hold_tag  <= rd_rec.tag;
            r_hold_slot <= r_cnt;
        end
        if (i_cmd.out_ld) begin
            r_out_tag <= '0;
            r_last    <= 1'b1;
            case (i_cmd.out_sel)
                OSEL_RUN, OSEL_RUN_LAST: begin
                    r_status   <= ST_RUN;
                    r_out_tag  <= r_hold_tag;
                    r_out_slot <= to_out_slot(r_hold_slot);
                    r_last     <= (i_cmd.out_sel == OSEL_RUN_LAST);
                end
                OSEL_ADDED: begin
                    r_status   <= ST_ADDED;
                    r_out_slot <= to_out_slot(r_cnt);
                end
                OSEL_FULL: begin
                    r_status   <= ST_FULL;
                    r_out_slot <= '0;
                end
                OSEL_DEL: begin
                    r_status   <= del_hit ? ST_DELETED : ST_EMPTY;
                    r_out_slot <= r_idx;
                end
                default: begin
                    r_status   <= ST_EMPTY;
                    r_out_slot <= '0;
                end
            endcase
        end
    end

    assign o_sts.out_free   = out_free;
    assign o_sts.slot_free  = !r_valid[r_cnt];
    assign o_sts.run        = r_valid[r_cnt] && (rd_rec.pending != '0);
    assign o_sts.cnt_last   = cnt_last;
    assign o_sts.found_last = (r_found == FOUND_W'(MAX_RESULTS - 1));
    assign o_sts.hold_valid = r_hold_valid;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_out_tag   = r_out_tag;
    assign o_out_slot  = r_out_slot;
    assign o_last      = r_last;

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_ld |-> out_free)
        else $error("output register loaded while a word still waits");

    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (r_cnt != n_cnt))
        else $error("slot store written at the address being read");

    a_take_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.disp_take |=> r_hold_valid && (r_found != '0))
        else $error("dispatch take did not leave a held run word");

    a_delete_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.del_do && del_hit) |=> !r_valid[$past(del_sel)])
        else $error("deleted slot still marked valid");

endmodule

### rtl/cttt_ctrl.sv
`timescale 1ns / 1ps
// Controller: request sequencing and slot scan control.
module cttt_ctrl
    import cttt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [REQ_W-1:0] i_req_type,
    output logic             o_in_ready,
    input  t_dp_sts          i_sts,
    output t_dp_cmd          o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_ADD,
        S_DEL,
        S_DISP,
        S_FLUSH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.out_sel = OSEL_RUN;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.ld_req  = 1'b1;
                    o_cmd.cnt_clr = 1'b1;
                    case (t_req'(i_req_type))
                        REQ_TICK: n_state = S_TICK;
                        REQ_ADD:  n_state = S_ADD;
                        REQ_DEL:  n_state = S_DEL;
                        REQ_DISP: n_state = S_DISP;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_TICK: begin
                o_cmd.tick_wr = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = S_IDLE;
                end
            end
            S_ADD: begin
                if (i_sts.slot_free) begin
                    if (i_sts.out_free) begin
                        o_cmd.add_wr  = 1'b1;
                        o_cmd.out_ld  = 1'b1;
                        o_cmd.out_sel = OSEL_ADDED;
                        o_cmd.cnt_inc = 1'b1;
                        n_state       = S_IDLE;
                    end
                end else if (i_sts.cnt_last) begin
                    if (i_sts.out_free) begin
                        o_cmd.out_ld  = 1'b1;
                        o_cmd.out_sel = OSEL_FULL;
                        n_state       = S_IDLE;
                    end
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            S_DEL: begin
                if (i_sts.out_free) begin
                    o_cmd.del_do  = 1'b1;
                    o_cmd.out_ld  = 1'b1;
                    o_cmd.out_sel = OSEL_DEL;
                    n_state       = S_IDLE;
                end
            end
            S_DISP: begin
                if (i_sts.run) begin
                    if (!i_sts.hold_valid || i_sts.out_free) begin
                        o_cmd.disp_take = 1'b1;
                        o_cmd.out_ld    = i_sts.hold_valid;
                        o_cmd.out_sel   = OSEL_RUN;
                        o_cmd.cnt_inc   = 1'b1;
                        if (i_sts.found_last || i_sts.cnt_last) begin
                            n_state = S_FLUSH;
                        end
                    end
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                    if (i_sts.cnt_last) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!i_sts.hold_valid) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_sel  = OSEL_RUN_LAST;
                    o_cmd.hold_clr = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/cooperative_task_timer_table.sv
`timescale 1ns / 1ps
// Top level of the cooperative task timer table.
//
// A table of SLOTS task slots (valid mark, tag, delay, period, pending count)
// served one request at a time. The request word is taken only while the
// block is idle; the next request may be taken while the previous result
// word still waits in the output register. Every scan visits one slot per
// cycle through the single-read slot store unless the output side stalls
// it. A tick scans every slot; an add scans up to the first free slot, or
// every slot when the table is full; a delete needs no scan; a dispatch
// scans every slot, and it emits at most 16 run words, the last one
// marked with last. A dispatch run word is held back one slot so the last
// mark is known when it leaves. Tick and an empty dispatch produce no
// result word. No clearing pass follows reset: valid marks sit in
// flip-flops and reset clears them at once.
module cooperative_task_timer_table
    import cttt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [REQ_W-1:0]      i_req_type,
    input  logic [TAG_W-1:0]      i_task_tag,
    input  logic [TICKS_W-1:0]    i_delay_ticks,
    input  logic [TICKS_W-1:0]    i_period_ticks,
    input  logic [IDX_W-1:0]      i_slot_index,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [STATUS_W-1:0]   o_status,
    output logic [TAG_W-1:0]      o_out_tag,
    output logic [OUT_SLOT_W-1:0] o_out_slot,
    output logic                  o_last
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequence requests and drive the scan
    cttt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_req_type(i_req_type),
        .o_in_ready(o_in_ready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    // hold the slot table and the result word
    cttt_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_task_tag    (i_task_tag),
        .i_delay_ticks (i_delay_ticks),
        .i_period_ticks(i_period_ticks),
        .i_slot_index  (i_slot_index),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_out_tag     (o_out_tag),
        .o_out_slot    (o_out_slot),
        .o_last        (o_last)
    );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the cooperative task timer table: directed and random requests.
module testbench;
    import cttt_pkg::*;

    // Cycles without any accepted word before the run is declared hung. The
    // longest correct quiet stretch is the receiver hold-off plus a full scan.
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_OFF_CYCLES = 400;
    // Let a tick or an empty dispatch finish its scan before declaring idle.
    localparam int SETTLE_CYCLES   = 2 * SLOTS + 8;
    localparam int MAX_SHOWN       = 10;
    localparam int PEND_MAX        = (1 << PEND_W) - 1;

    typedef struct {
        t_status               status;
        logic [TAG_W-1:0]      tag;
        logic [OUT_SLOT_W-1:0] slot;
        logic                  last;
    } t_result_word;

    // Ready patterns of the result side; each one lasts a random stretch.
    typedef enum {
        SINK_OPEN,
        SINK_COIN,
        SINK_CADENCE,
        SINK_SPARSE
    } t_sink_mode;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_ready;
    logic [REQ_W-1:0]      i_req_type     = '0;
    logic [TAG_W-1:0]      i_task_tag     = '0;
    logic [TICKS_W-1:0]    i_delay_ticks  = '0;
    logic [TICKS_W-1:0]    i_period_ticks = '0;
    logic [IDX_W-1:0]      i_slot_index   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready    = 1'b0;
    logic [STATUS_W-1:0]   o_status;
    logic [TAG_W-1:0]      o_out_tag;
    logic [OUT_SLOT_W-1:0] o_out_slot;
    logic                  o_last;

    cooperative_task_timer_table dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_task_tag     (i_task_tag),
        .i_delay_ticks  (i_delay_ticks),
        .i_period_ticks (i_period_ticks),
        .i_slot_index   (i_slot_index),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_out_tag      (o_out_tag),
        .o_out_slot     (o_out_slot),
        .o_last         (o_last)
    );

    // Shadow copy of the slot table, advanced once per accepted request word.
    logic               tbl_live   [SLOTS];
    logic [TAG_W-1:0]   tbl_tag    [SLOTS];
    logic [TICKS_W-1:0] tbl_delay  [SLOTS];
    logic [TICKS_W-1:0] tbl_period [SLOTS];
    logic [PEND_W-1:0]  tbl_pend   [SLOTS];

    // Result words still owed by the block, oldest first.
    t_result_word expected_words[$];

    int mismatch_count   = 0;
    int idle_cycles      = 0;
    int burst_left       = 0;
    bit hold_off_request = 1'b0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Table predictor
    // ------------------------------------------------------------------

    function automatic void clear_table_slot(int s);
        tbl_live[s]   = 1'b0;
        tbl_tag[s]    = '0;
        tbl_delay[s]  = '0;
        tbl_period[s] = '0;
        tbl_pend[s]   = '0;
    endfunction

    function automatic void push_word(t_status st, logic [TAG_W-1:0] tag,
                                      logic [OUT_SLOT_W-1:0] slot, logic last);
        t_result_word w;
        w.status = st;
        w.tag    = tag;
        w.slot   = slot;
        w.last   = last;
        expected_words.push_back(w);
    endfunction

    // Advance the shadow table by one request and queue the words it owes.
    function automatic void table_apply_request(t_req req, logic [TAG_W-1:0] tag,
                                                logic [TICKS_W-1:0] dly,
                                                logic [TICKS_W-1:0] per,
                                                logic [IDX_W-1:0] idx);
        int s;
        int ran_slot[$];
        int ran_tag[$];
        case (req)
            REQ_TICK: begin
                // Age every live slot; a slot at zero delay gains a run and
                // reloads only when periodic, so a one-shot keeps piling up.
                for (s = 0; s < SLOTS; s++) begin
                    if (tbl_live[s]) begin
                        if (tbl_delay[s] == '0) begin
                            if (tbl_pend[s] != PEND_W'(PEND_MAX))
                                tbl_pend[s] = tbl_pend[s] + 1'b1;
                            if (tbl_period[s] != '0)
                                tbl_delay[s] = tbl_period[s];
                        end else begin
                            tbl_delay[s] = tbl_delay[s] - 1'b1;
                        end
                    end
                end
            end
            REQ_ADD: begin
                s = 0;
                while (s < SLOTS && tbl_live[s])
                    s++;
                if (s < SLOTS) begin
                    tbl_live[s]   = 1'b1;
                    tbl_tag[s]    = tag;
                    tbl_delay[s]  = dly;
                    tbl_period[s] = per;
                    tbl_pend[s]   = '0;
                    push_word(ST_ADDED, '0, OUT_SLOT_W'(s), 1'b1);
                end else begin
                    push_word(ST_FULL, '0, '0, 1'b1);
                end
            end
            REQ_DEL: begin
                if (int'(idx) < SLOTS && tbl_live[idx]) begin
                    clear_table_slot(int'(idx));
                    push_word(ST_DELETED, '0, OUT_SLOT_W'(idx), 1'b1);
                end else begin
                    push_word(ST_EMPTY, '0, OUT_SLOT_W'(idx), 1'b1);
                end
            end
            REQ_DISP: begin
                // Scan in slot order, one run per pending slot, capped per
                // request; a one-shot slot is freed as soon as it runs.
                for (s = 0; s < SLOTS && ran_slot.size() < MAX_RESULTS; s++) begin
                    if (tbl_live[s] && tbl_pend[s] != '0) begin
                        ran_slot.push_back(s);
                        ran_tag.push_back(int'(tbl_tag[s]));
                        tbl_pend[s] = tbl_pend[s] - 1'b1;
                        if (tbl_period[s] == '0)
                            clear_table_slot(s);
                    end
                end
                for (s = 0; s < ran_slot.size(); s++)
                    push_word(ST_RUN, TAG_W'(ran_tag[s]), OUT_SLOT_W'(ran_slot[s]),
                              s == ran_slot.size() - 1);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one request word at the falling edge, hold it until taken, then
    // either carry on in the burst or drop valid for a random gap.
    task automatic issue_request(input t_req req, input logic [TAG_W-1:0] tag,
                                 input logic [TICKS_W-1:0] dly,
                                 input logic [TICKS_W-1:0] per,
                                 input logic [IDX_W-1:0] idx);
        i_in_valid     = 1'b1;
        i_req_type     = req;
        i_task_tag     = tag;
        i_delay_ticks  = dly;
        i_period_ticks = per;
        i_slot_index   = idx;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        table_apply_request(req, tag, dly, per, idx);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 7);
        end
    endtask

    // Drop valid and hold until every owed word has come back and the last
    // silent scan has had time to finish.
    task automatic wait_results_drained();
        i_in_valid = 1'b0;
        while (expected_words.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One random request: mostly short delays and periods so slots fire often,
    // with occasional full-range values; deletes mostly aim at live slots.
    task automatic send_random_request();
        int                 pick;
        int                 s;
        int                 live_list[$];
        t_req               req;
        logic [TAG_W-1:0]   tag;
        logic [TICKS_W-1:0] dly;
        logic [TICKS_W-1:0] per;
        logic [IDX_W-1:0]   idx;
        pick = $urandom_range(0, 99);
        tag  = TAG_W'($urandom);
        dly  = TICKS_W'($urandom);
        per  = TICKS_W'($urandom);
        idx  = IDX_W'($urandom);
        if (pick < 35)
            req = REQ_TICK;
        else if (pick < 60)
            req = REQ_ADD;
        else if (pick < 80)
            req = REQ_DEL;
        else
            req = REQ_DISP;
        if (req == REQ_ADD) begin
            dly = ($urandom_range(0, 7) == 0) ? TICKS_W'($urandom)
                                              : TICKS_W'($urandom_range(0, 4));
            per = ($urandom_range(0, 7) == 0) ? TICKS_W'($urandom)
                                              : TICKS_W'($urandom_range(0, 5));
        end
        if (req == REQ_DEL && $urandom_range(0, 9) < 7) begin
            for (s = 0; s < SLOTS; s++)
                if (tbl_live[s])
                    live_list.push_back(s);
            if (live_list.size() != 0)
                idx = IDX_W'(live_list[$urandom_range(0, live_list.size() - 1)]);
        end
        issue_request(req, tag, dly, per, idx);
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Drive ready at the falling edge on a pattern of its own; serve a
    // requested hold-off by keeping ready low for a counted stretch.
    initial begin : result_sink
        t_sink_mode mode;
        int         mode_left;
        int         phase;
        mode      = SINK_OPEN;
        mode_left = 0;
        phase     = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                i_out_ready      = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end
            if (mode_left == 0) begin
                mode      = t_sink_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            phase++;
            case (mode)
                SINK_OPEN:    i_out_ready = 1'b1;
                SINK_COIN:    i_out_ready = 1'($urandom_range(0, 1));
                SINK_CADENCE: i_out_ready = (phase % 5) >= 2;
                default:      i_out_ready = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    function automatic void log_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
            $display("%0t ns: %s", $realtime, msg);
    endfunction

    // Compare each accepted result word with the oldest owed word, and count
    // cycles in which neither channel moves a word.
    initial begin : result_check
        t_result_word want;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (o_out_valid === 1'b1 && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    log_mismatch($sformatf(
                        "unexpected result word: status %0d tag %0d slot %0d last %0d",
                        o_status, o_out_tag, o_out_slot, o_last));
                end else begin
                    want = expected_words.pop_front();
                    if (o_status !== want.status || o_out_tag !== want.tag ||
                        o_out_slot !== want.slot || o_last !== want.last)
                        log_mismatch($sformatf(
                            {"result word mismatch: expected status %0d tag %0d slot %0d ",
                             "last %0d, got status %0d tag %0d slot %0d last %0d"},
                            want.status, want.tag, want.slot, want.last,
                            o_status, o_out_tag, o_out_slot, o_last));
                end
            end
        end
    end

    initial begin : watchdog
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Dispatch on an empty table owes nothing; delete of the top index is empty.
    task automatic test_empty_table();
        issue_request(REQ_DISP, '0, '0, '0, '0);
        issue_request(REQ_DEL, 8'hFF, 16'hFFFF, 16'hFFFF, IDX_W'(SLOTS - 1));
    endtask

    // A one-shot at zero delay gains a run on every tick yet runs once; a
    // periodic slot reloads from the full-range period; delete twice.
    task automatic test_one_shot_and_periodic();
        issue_request(REQ_ADD, 8'hFF, 16'd0, 16'd0, '0);
        issue_request(REQ_ADD, 8'h00, 16'd1, 16'hFFFF, '0);
        issue_request(REQ_TICK, '0, '0, '0, '0);
        issue_request(REQ_TICK, '0, '0, '0, '0);
        issue_request(REQ_DISP, '0, '0, '0, '0);
        issue_request(REQ_DEL, '0, '0, '0, 4'd1);
        issue_request(REQ_DEL, '0, '0, '0, 4'd1);
    endtask

    // Fill every slot, bounce one add off the full table, then fire all slots
    // at once so one dispatch emits the most runs it can.
    task automatic test_full_table_dispatch();
        int i;
        for (i = 0; i < SLOTS; i++)
            issue_request(REQ_ADD, TAG_W'($urandom), 16'd0,
                          (i == SLOTS - 1) ? 16'hFFFF : TICKS_W'(i + 1), '0);
        issue_request(REQ_ADD, 8'hFF, 16'hFFFF, 16'hFFFF, '0);
        issue_request(REQ_TICK, '0, '0, '0, '0);
        issue_request(REQ_DISP, '0, '0, '0, '0);
        issue_request(REQ_DISP, '0, '0, '0, '0);
    endtask

    // Park a one-shot at zero delay in a freed slot and tick it one step past
    // the pending ceiling: a saturating count still holds a run, a wrapping
    // one holds none.
    task automatic test_pending_saturation();
        issue_request(REQ_DEL, '0, '0, '0, '0);
        issue_request(REQ_ADD, 8'h5A, 16'd0, 16'd0, '0);
        repeat (PEND_MAX + 1) issue_request(REQ_TICK, '0, '0, '0, '0);
        issue_request(REQ_DISP, '0, '0, '0, '0);
    endtask

    task automatic test_random_traffic(int count);
        repeat (count) send_random_request();
    endtask

    // Hold the result side off for a long stretch while requests keep coming,
    // so the block backs up and stalls its request side.
    task automatic test_result_backpressure();
        hold_off_request = 1'b1;
        burst_left       = 30;
        repeat (20) send_random_request();
    endtask

    // Pause the request side until every owed word has come, then resume.
    task automatic test_drain_then_traffic(int count);
        wait_results_drained();
        repeat (count) send_random_request();
    endtask

    initial begin : main
        int s;
        for (s = 0; s < SLOTS; s++)
            clear_table_slot(s);
        // Hold reset low, then release it at a falling edge.
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_empty_table();
        test_one_shot_and_periodic();
        test_full_table_dispatch();
        test_pending_saturation();
        test_random_traffic(8);
        test_result_backpressure();
        test_drain_then_traffic(8);

        wait_results_drained();
        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### sim.f
rtl/cttt_pkg.sv
rtl/cttt_ram.sv
rtl/cttt_dp.sv
rtl/cttt_ctrl.sv
rtl/cooperative_task_timer_table.sv
tb/testbench.sv
